// ===== hdl/gsc_pkg.sv =====
package gsc_pkg;

  // field and syndrome geometry
  localparam int unsigned SYM_BITS = 8;
  localparam int unsigned NUM_SYN  = 16;
  localparam int unsigned IDX_W    = $clog2(NUM_SYN);
  localparam int unsigned CNT_W    = 5;

  // snapshot queue between accumulators and drain
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_POLY = 1'b0,
    CFG_SYN_COUNT  = 1'b1
  } cfg_reg_t;

  typedef logic [SYM_BITS-1:0]       sym_t;
  typedef sym_t [NUM_SYN-1:0]        syn_vec_t;

  // one finished codeword: syndromes plus index of the final one to emit
  typedef struct packed {
    syn_vec_t         syn;
    logic [IDX_W-1:0] last_idx;
  } snap_t;

  // multiply by x, reduced by x^SYM_BITS + poly
  function automatic sym_t times_x(sym_t v, sym_t poly);
    sym_t r;
    r = {v[SYM_BITS-2:0], 1'b0};
    if (v[SYM_BITS-1]) r = r ^ poly;
    return r;
  endfunction

  // shift-and-add field multiply, MSB of b first
  function automatic sym_t field_mul(sym_t a, sym_t b, sym_t poly);
    sym_t r;
    r = '0;
    for (int k = SYM_BITS - 1; k >= 0; k--) begin
      r = times_x(r, poly);
      if (b[k]) r = r ^ a;
    end
    return r;
  endfunction

  // x^k: plain shift below the field width, then at most a few reductions
  function automatic sym_t alpha_step(sym_t poly, int unsigned k);
    sym_t v;
    if (k < SYM_BITS) v = sym_t'(1) << k;
    else v = poly;
    for (int j = 0; j < int'(NUM_SYN) - int'(SYM_BITS); j++) begin
      if (k >= SYM_BITS + 1 + j) v = times_x(v, poly);
    end
    return v;
  endfunction

endpackage

// ===== hdl/gsc_front.sv =====
module gsc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  gsc_pkg::sym_t               symbol,
  input  logic                        last,
  input  gsc_pkg::sym_t               field_poly,
  input  logic [gsc_pkg::CNT_W-1:0]   syn_count,
  output logic                        snap_push,
  output gsc_pkg::snap_t              snap
);

  gsc_pkg::syn_vec_t acc_r, acc_nxt;
  gsc_pkg::syn_vec_t pow_r, pow_nxt;
  gsc_pkg::syn_vec_t acc_upd;
  gsc_pkg::syn_vec_t pow_upd;

  // one lane per syndrome: accumulate symbol * power, advance power
  for (genvar i = 0; i < gsc_pkg::NUM_SYN; i++) begin : g_lane
    gsc_pkg::sym_t step;

    assign step       = gsc_pkg::alpha_step(field_poly, i + 1);
    assign acc_upd[i] = acc_r[i] ^ gsc_pkg::field_mul(symbol, pow_r[i], field_poly);
    assign pow_upd[i] = gsc_pkg::field_mul(pow_r[i], step, field_poly);
  end

  // lane state: update on every request, restart after the codeword end
  always_comb begin
    acc_nxt = acc_r;
    pow_nxt = pow_r;
    if (take) begin
      if (last) begin
        acc_nxt = '0;
        for (int i = 0; i < gsc_pkg::NUM_SYN; i++) pow_nxt[i] = gsc_pkg::sym_t'(1);
      end else begin
        acc_nxt = acc_upd;
        pow_nxt = pow_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      for (int i = 0; i < gsc_pkg::NUM_SYN; i++) pow_r[i] <= gsc_pkg::sym_t'(1);
    end else begin
      acc_r <= acc_nxt;
      pow_r <= pow_nxt;
    end
  end

  // codeword end: hand the finished syndromes to the back end
  always_comb begin
    snap_push = take & last;
    snap.syn  = acc_upd;
    if (syn_count == '0) begin
      snap.last_idx = '0;
    end else if (syn_count >= gsc_pkg::CNT_W'(gsc_pkg::NUM_SYN)) begin
      snap.last_idx = gsc_pkg::IDX_W'(gsc_pkg::NUM_SYN - 1);
    end else begin
      snap.last_idx = gsc_pkg::IDX_W'(syn_count - 1'b1);
    end
  end

endmodule

// ===== hdl/gsc_back.sv =====
module gsc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        snap_push,
  input  gsc_pkg::snap_t              snap,
  output logic                        full,
  output logic                        empty,
  input  logic                        pop,
  output logic [gsc_pkg::IDX_W-1:0]   syn_index,
  output gsc_pkg::sym_t               syn_value,
  output logic                        syn_last
);

  gsc_pkg::snap_t                q_r [gsc_pkg::QDEPTH];
  logic [gsc_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [gsc_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [gsc_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [gsc_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  gsc_pkg::snap_t                head;
  logic                          take_out;
  logic                          retire;

  assign full     = (cnt_r == gsc_pkg::QCNT_W'(gsc_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign head     = q_r[rd_ptr_r];
  assign take_out = pop & ~empty;
  assign retire   = take_out & (idx_r == head.last_idx);

  // result ports come straight from the head snapshot
  assign syn_index = idx_r;
  assign syn_value = head.syn[idx_r];
  assign syn_last  = (idx_r == head.last_idx);

  // pointer, count and drain index
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    if (snap_push) wr_ptr_nxt = wr_ptr_r + 1'b1;
    if (take_out) begin
      if (retire) begin
        rd_ptr_nxt = rd_ptr_r + 1'b1;
        idx_nxt    = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (snap_push && !retire) cnt_nxt = cnt_r + 1'b1;
    else if (!snap_push && retire) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      idx_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // snapshot storage, no reset needed
  always_ff @(posedge clk) begin
    if (snap_push) q_r[wr_ptr_r] <= snap;
  end

endmodule

// ===== hdl/gf_syndrome_calculator_top.sv =====
// Channel  | Direction | Handshake           | Payload
// in_      | request   | in_push / in_full   | in_symbol[7:0], in_last
// out_     | result    | out_pop / out_empty | out_syndrome_index[3:0],
//          |           |                     | out_syndrome_value[7:0], out_last_out
// cfg_     | write     | cfg_valid/cfg_ready | cfg_index[0], cfg_data[7:0]
//
// One symbol per clock while in_full is low: all 16 syndrome lanes update in the cycle of acceptance.
// A codeword end pushes its syndromes into a two-entry snapshot queue; the back
// end drains one syndrome per clock on pop, so output length per codeword is
// the configured count, a count of zero giving one and large counts giving 16.
// in_full rises only while both snapshot slots wait.
// Synchronous active-low reset; no clearing pass. cfg_ready is always high.
module gf_syndrome_calculator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [gsc_pkg::SYM_BITS-1:0]    in_symbol,
  input  logic                            in_last,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [gsc_pkg::IDX_W-1:0]       out_syndrome_index,
  output logic [gsc_pkg::SYM_BITS-1:0]    out_syndrome_value,
  output logic                            out_last_out,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  gsc_pkg::sym_t               field_poly_r;
  logic [gsc_pkg::CNT_W-1:0]   syn_count_r;
  logic                        take;
  logic                        snap_push;
  gsc_pkg::snap_t              snap;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_poly_r <= gsc_pkg::sym_t'(29);
      syn_count_r  <= gsc_pkg::CNT_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (gsc_pkg::cfg_reg_t'(cfg_index))
        gsc_pkg::CFG_FIELD_POLY: field_poly_r <= cfg_data[gsc_pkg::SYM_BITS-1:0];
        gsc_pkg::CFG_SYN_COUNT:  syn_count_r  <= cfg_data[gsc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign take = in_push & ~in_full;

  gsc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .symbol     (in_symbol),
    .last       (in_last),
    .field_poly (field_poly_r),
    .syn_count  (syn_count_r),
    .snap_push  (snap_push),
    .snap       (snap)
  );

  gsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_push (snap_push),
    .snap      (snap),
    .full      (in_full),
    .empty     (out_empty),
    .pop       (out_pop),
    .syn_index (out_syndrome_index),
    .syn_value (out_syndrome_value),
    .syn_last  (out_last_out)
  );

endmodule
